[hw/rtl/lpmd_pkg.sv]
package lpmd_pkg;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_ADD_CODE    = 2'd0;
    localparam logic [1:0] REG_UPDATE_CODE = 2'd1;
    localparam logic [1:0] REG_REMOVE_CODE = 2'd2;

    // Message kinds
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    // Field tags
    localparam logic [3:0] FK_TYPE     = 4'd0;
    localparam logic [3:0] FK_NAME_LEN = 4'd1;
    localparam logic [3:0] FK_NAME     = 4'd2;
    localparam logic [3:0] FK_TYPE_LEN = 4'd3;
    localparam logic [3:0] FK_TYPE_TXT = 4'd4;
    localparam logic [3:0] FK_PORT     = 4'd5;
    localparam logic [3:0] FK_REC_TYPE = 4'd6;
    localparam logic [3:0] FK_DATA_LEN = 4'd7;
    localparam logic [3:0] FK_DATA     = 4'd8;

    typedef enum logic [3:0] {
        PH_TYPE    = 4'd0,
        PH_NLEN_LO = 4'd1,
        PH_NLEN_HI = 4'd2,
        PH_NAME    = 4'd3,
        PH_TLEN_LO = 4'd4,
        PH_TLEN_HI = 4'd5,
        PH_TTEXT   = 4'd6,
        PH_PORT_LO = 4'd7,
        PH_PORT_HI = 4'd8,
        PH_RR_LO   = 4'd9,
        PH_RR_HI   = 4'd10,
        PH_DLEN_LO = 4'd11,
        PH_DLEN_HI = 4'd12,
        PH_DATA    = 4'd13
    } t_phase;

    typedef struct packed {
        logic [7:0] add_code;
        logic [7:0] update_code;
        logic [7:0] remove_code;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] field_kind;
        logic [1:0] message_kind;
        logic       last_of_message;
        logic       parse_error;
    } t_result;

endpackage

[hw/rtl/lpmd_cfg.sv]
module lpmd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpmd_pkg::PADDR_W-1:0]  paddr,
    input  logic [lpmd_pkg::PDATA_W-1:0]  pwdata,
    output logic [lpmd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output lpmd_pkg::t_cfg                o_cfg
);

    lpmd_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;
    logic [7:0]     rd_val;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.add_code    <= 8'd0;
            r_cfg.update_code <= 8'd1;
            r_cfg.remove_code <= 8'd2;
        end else if (wr_en) begin
            case (reg_idx)
                lpmd_pkg::REG_ADD_CODE:    r_cfg.add_code    <= pwdata[7:0];
                lpmd_pkg::REG_UPDATE_CODE: r_cfg.update_code <= pwdata[7:0];
                lpmd_pkg::REG_REMOVE_CODE: r_cfg.remove_code <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            lpmd_pkg::REG_ADD_CODE:    rd_val = r_cfg.add_code;
            lpmd_pkg::REG_UPDATE_CODE: rd_val = r_cfg.update_code;
            lpmd_pkg::REG_REMOVE_CODE: rd_val = r_cfg.remove_code;
            default:                   rd_val = 8'd0;
        endcase
    end

    assign prdata = {{(lpmd_pkg::PDATA_W-8){1'b0}}, rd_val};

endmodule

[hw/rtl/lpmd_parser.sv]
module lpmd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte_in,
    input  lpmd_pkg::t_cfg    i_cfg,
    output lpmd_pkg::t_result o_result
);

    lpmd_pkg::t_phase r_phase, n_phase;
    logic [15:0]      r_bytes_left, n_bytes_left;
    logic [7:0]       r_low_len, n_low_len;
    logic [1:0]       r_kind, n_kind;
    logic             r_error, n_error;

    logic [15:0] len;
    logic [15:0] dec;
    logic        dec_zero;
    logic        len_zero;
    logic        last;

    assign len      = {i_byte_in, r_low_len};
    assign len_zero = (len == 16'd0);
    assign dec      = r_bytes_left - 16'd1;
    assign dec_zero = (dec == 16'd0);

    // Next state
    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_low_len    = r_low_len;
        n_kind       = r_kind;
        n_error      = r_error;
        last         = 1'b0;
        if (!r_error) begin
            case (r_phase)
                lpmd_pkg::PH_NLEN_LO: begin
                    n_low_len = i_byte_in;
                    n_phase   = lpmd_pkg::PH_NLEN_HI;
                end
                lpmd_pkg::PH_NLEN_HI, lpmd_pkg::PH_NAME: begin
                    if (r_phase == lpmd_pkg::PH_NAME) begin
                        n_bytes_left = dec;
                    end else if (!len_zero) begin
                        n_bytes_left = len;
                        n_phase      = lpmd_pkg::PH_NAME;
                    end
                    // end of name field: branch on message kind
                    if ((r_phase == lpmd_pkg::PH_NAME) ? dec_zero : len_zero) begin
                        if (r_kind == lpmd_pkg::KIND_ADD) begin
                            n_phase = lpmd_pkg::PH_TLEN_LO;
                        end else if (r_kind == lpmd_pkg::KIND_UPDATE) begin
                            n_phase = lpmd_pkg::PH_DLEN_LO;
                        end else begin
                            n_phase = lpmd_pkg::PH_TYPE;
                            last    = 1'b1;
                        end
                    end
                end
                lpmd_pkg::PH_TLEN_LO: begin
                    n_low_len = i_byte_in;
                    n_phase   = lpmd_pkg::PH_TLEN_HI;
                end
                lpmd_pkg::PH_TLEN_HI: begin
                    if (len_zero) begin
                        n_phase = lpmd_pkg::PH_PORT_LO;
                    end else begin
                        n_bytes_left = len;
                        n_phase      = lpmd_pkg::PH_TTEXT;
                    end
                end
                lpmd_pkg::PH_TTEXT: begin
                    n_bytes_left = dec;
                    if (dec_zero) begin
                        n_phase = lpmd_pkg::PH_PORT_LO;
                    end
                end
                lpmd_pkg::PH_PORT_LO: n_phase = lpmd_pkg::PH_PORT_HI;
                lpmd_pkg::PH_PORT_HI: n_phase = lpmd_pkg::PH_RR_LO;
                lpmd_pkg::PH_RR_LO:   n_phase = lpmd_pkg::PH_RR_HI;
                lpmd_pkg::PH_RR_HI:   n_phase = lpmd_pkg::PH_DLEN_LO;
                lpmd_pkg::PH_DLEN_LO: begin
                    n_low_len = i_byte_in;
                    n_phase   = lpmd_pkg::PH_DLEN_HI;
                end
                lpmd_pkg::PH_DLEN_HI: begin
                    if (len_zero) begin
                        n_phase = lpmd_pkg::PH_TYPE;
                        last    = 1'b1;
                    end else begin
                        n_bytes_left = len;
                        n_phase      = lpmd_pkg::PH_DATA;
                    end
                end
                lpmd_pkg::PH_DATA: begin
                    n_bytes_left = dec;
                    if (dec_zero) begin
                        n_phase = lpmd_pkg::PH_TYPE;
                        last    = 1'b1;
                    end
                end
                default: begin
                    // type byte; priority add, update, remove
                    if (i_byte_in == i_cfg.add_code) begin
                        n_kind  = lpmd_pkg::KIND_ADD;
                        n_phase = lpmd_pkg::PH_NLEN_LO;
                    end else if (i_byte_in == i_cfg.update_code) begin
                        n_kind  = lpmd_pkg::KIND_UPDATE;
                        n_phase = lpmd_pkg::PH_NLEN_LO;
                    end else if (i_byte_in == i_cfg.remove_code) begin
                        n_kind  = lpmd_pkg::KIND_REMOVE;
                        n_phase = lpmd_pkg::PH_NLEN_LO;
                    end else begin
                        n_error = 1'b1;
                        n_phase = lpmd_pkg::PH_TYPE;
                    end
                end
            endcase
        end
    end

    // Result tag
    always_comb begin
        o_result.data_byte       = i_byte_in;
        o_result.field_kind      = lpmd_pkg::FK_TYPE;
        o_result.message_kind    = n_kind;
        o_result.last_of_message = last;
        o_result.parse_error     = n_error;
        case (r_phase)
            lpmd_pkg::PH_NLEN_LO, lpmd_pkg::PH_NLEN_HI:
                o_result.field_kind = lpmd_pkg::FK_NAME_LEN;
            lpmd_pkg::PH_NAME:
                o_result.field_kind = lpmd_pkg::FK_NAME;
            lpmd_pkg::PH_TLEN_LO, lpmd_pkg::PH_TLEN_HI:
                o_result.field_kind = lpmd_pkg::FK_TYPE_LEN;
            lpmd_pkg::PH_TTEXT:
                o_result.field_kind = lpmd_pkg::FK_TYPE_TXT;
            lpmd_pkg::PH_PORT_LO, lpmd_pkg::PH_PORT_HI:
                o_result.field_kind = lpmd_pkg::FK_PORT;
            lpmd_pkg::PH_RR_LO, lpmd_pkg::PH_RR_HI:
                o_result.field_kind = lpmd_pkg::FK_REC_TYPE;
            lpmd_pkg::PH_DLEN_LO, lpmd_pkg::PH_DLEN_HI:
                o_result.field_kind = lpmd_pkg::FK_DATA_LEN;
            lpmd_pkg::PH_DATA:
                o_result.field_kind = lpmd_pkg::FK_DATA;
            default:
                o_result.field_kind = lpmd_pkg::FK_TYPE;
        endcase
        if (n_error) begin
            o_result.field_kind   = lpmd_pkg::FK_TYPE;
            o_result.message_kind = lpmd_pkg::KIND_ADD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= lpmd_pkg::PH_TYPE;
            r_bytes_left <= 16'd0;
            r_low_len    <= 8'd0;
            r_kind       <= lpmd_pkg::KIND_ADD;
            r_error      <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_low_len    <= n_low_len;
            r_kind       <= n_kind;
            r_error      <= n_error;
        end
    end

endmodule

[hw/rtl/lpmd_outbuf.sv]
module lpmd_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  lpmd_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_full,
    output logic              o_valid,
    output lpmd_pkg::t_result o_result
);

    logic              r_out_valid;
    logic              r_skid_valid;
    lpmd_pkg::t_result r_out;
    lpmd_pkg::t_result r_skid;
    logic              out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_accept;
            r_skid_valid <= 1'b0;
        end else if (i_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end
        if (!out_free && i_accept) begin
            r_skid <= i_result;
        end
    end

endmodule

[hw/rtl/length_prefixed_message_deframer_unit.sv]
// Each accepted byte's result is registered in the output register, or in the one-entry
// skid stage while the output is stalled. Throughput: one byte per cycle while the skid
// entry is empty; a byte's phase/length update is a single pass of logic ahead of the output register.
// Reset (synchronous, active low): parser returns to awaiting a type byte,
// length and kind state clear, the sticky error clears, codes go to 0/1/2.
module length_prefixed_message_deframer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // APB-style configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpmd_pkg::PADDR_W-1:0]  paddr,
    input  logic [lpmd_pkg::PDATA_W-1:0]  pwdata,
    output logic [lpmd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,

    // Input item channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_byte_in,

    // Result item channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_data_byte,
    output logic [3:0]                    o_field_kind,
    output logic [1:0]                    o_message_kind,
    output logic                          o_last_of_message,
    output logic                          o_parse_error
);

    lpmd_pkg::t_cfg    cfg;
    lpmd_pkg::t_result parse_res;
    lpmd_pkg::t_result out_res;
    logic              buf_full;
    logic              in_accept;

    // Input is held off only while the skid entry is occupied, so a byte
    // can be taken even when the output item is stalled downstream.
    assign o_stall   = buf_full;
    assign in_accept = i_valid && !buf_full;

    lpmd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Phase tracker: tags the byte and advances state on acceptance.
    lpmd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_byte_in (i_byte_in),
        .i_cfg     (cfg),
        .o_result  (parse_res)
    );

    // Output register plus skid entry.
    lpmd_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_result (parse_res),
        .i_stall  (i_stall),
        .o_full   (buf_full),
        .o_valid  (o_valid),
        .o_result (out_res)
    );

    assign o_data_byte       = out_res.data_byte;
    assign o_field_kind      = out_res.field_kind;
    assign o_message_kind    = out_res.message_kind;
    assign o_last_of_message = out_res.last_of_message;
    assign o_parse_error     = out_res.parse_error;

endmodule
